// File: rtl/fina_pkg.sv
package fina_pkg;

  // Table size default for the tanh knots
  localparam int unsigned TanhEntriesDefault = 256;

  // Field and register widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 12;
  localparam int unsigned NumTaps  = 5;
  localparam int unsigned WeightsW = NumTaps * CoefW;
  localparam int unsigned PostW    = 12;
  localparam int unsigned OutW     = 16;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = WeightsW;

  localparam logic [CfgIdxW-1:0] RegWeights   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBias      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPrescale  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegModGain   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegUseRelu   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPostscale = 3'd5;

  localparam logic [WeightsW-1:0]    WeightsReset   = '0;
  localparam logic signed [CoefW-1:0] BiasReset     = 12'sd0;
  localparam logic signed [CoefW-1:0] PrescaleReset = 12'sd256;
  localparam logic signed [CoefW-1:0] ModGainReset  = 12'sd0;
  localparam logic                    UseReluReset  = 1'b0;
  localparam logic [PostW-1:0]        PostscaleReset = 12'd1280;

  // Datapath widths and shifts
  localparam int unsigned InFracW   = 10;               // Q.8 -> Q.18 alignment
  localparam int unsigned ProdW     = 28;               // 12x16 signed product
  localparam int unsigned AccW      = 31;               // bias + five taps
  localparam int unsigned ScaleW    = 28;               // prescale + modulation
  localparam int unsigned PreW      = AccW + ScaleW;    // Q.36 product
  localparam int unsigned PreShift  = 20;               // Q.36 -> Q.16
  localparam int unsigned PW        = PreW - PreShift;  // pre-activation, Q.16
  localparam int unsigned AbsW      = 20;               // |p| clamped to 8.0
  localparam int unsigned KnotW     = 17;               // knot value, Q.16
  localparam int unsigned ActW      = 32;               // activation, Q.16
  localparam int unsigned PostShift = 14;               // Q.24 -> Q.10
  localparam int unsigned PostProdW = ActW + PostW + 1;

  localparam logic signed [OutW-1:0] OutMax = 16'sh7fff;
  localparam logic signed [OutW-1:0] OutMin = 16'sh8000;

  // Request and result payloads
  typedef struct packed {
    logic signed [SampleW-1:0] in_1;
    logic signed [SampleW-1:0] in_2;
    logic signed [SampleW-1:0] in_3;
    logic signed [SampleW-1:0] in_4;
    logic signed [SampleW-1:0] in_5;
    logic signed [SampleW-1:0] mod_in;
  } in_req_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_value;
    logic                   saturated;
  } out_rsp_t;

  // Register file contents
  typedef struct packed {
    logic [WeightsW-1:0]     weights;
    logic signed [CoefW-1:0] bias;
    logic signed [CoefW-1:0] prescale;
    logic signed [CoefW-1:0] mod_gain;
    logic                    use_relu;
    logic [PostW-1:0]        postscale;
  } cfg_t;

  // Stage hand-offs between pipeline sections
  typedef struct packed {
    logic                   valid;
    logic signed [PreW-1:0] pre;
  } pre_stage_t;

  typedef struct packed {
    logic                   valid;
    logic signed [ActW-1:0] act;
  } act_stage_t;

  // Restoring long division, used only while building the knot table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16/entries) in Q.30 from a series truncated after its 12th-order term
  function automatic logic [63:0] tanh_ratio(input int unsigned entries);
    logic [63:0]        one;
    logic [63:0]        h;
    logic [63:0]        term;
    logic signed [63:0] sum;
    one  = 64'd1 << 30;
    h    = udiv64(64'd16 << 30, 64'(entries));
    sum  = signed'(one);
    term = one;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * h) >> 30, 64'(k));
      if (k[0]) sum = sum - signed'(term);
      else      sum = sum + signed'(term);
    end
    return (sum > 0) ? unsigned'(sum) : 64'd0;
  endfunction

  // Next exp(-2x) sample in Q.30
  function automatic logic [63:0] tanh_next_e(input logic [63:0] e, input logic [63:0] r);
    logic [63:0] one;
    logic [63:0] nxt;
    one = 64'd1 << 30;
    nxt = (e * r + (one >> 1)) >> 30;
    return (nxt > one) ? one : nxt;
  endfunction

  // Knot value (1-e)/(1+e) in Q.16, rounded
  function automatic logic [63:0] tanh_knot(input logic [63:0] e);
    logic [63:0] one;
    logic [63:0] den;
    one = 64'd1 << 30;
    den = one + e;
    return udiv64(((one - e) << 16) + (den >> 1), den);
  endfunction

endpackage

// File: rtl/fina_stream_if.sv
interface fina_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/fina_cfg_regs.sv
module fina_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fina_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fina_pkg::CfgDataW-1:0]  cfg_data_i,
  output fina_pkg::cfg_t                 cfg_o
);
  import fina_pkg::*;

  cfg_t cfg_d, cfg_q;

  // Decode a write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWeights:   cfg_d.weights   = cfg_data_i[WeightsW-1:0];
        RegBias:      cfg_d.bias      = signed'(cfg_data_i[CoefW-1:0]);
        RegPrescale:  cfg_d.prescale  = signed'(cfg_data_i[CoefW-1:0]);
        RegModGain:   cfg_d.mod_gain  = signed'(cfg_data_i[CoefW-1:0]);
        RegUseRelu:   cfg_d.use_relu  = cfg_data_i[0];
        RegPostscale: cfg_d.postscale = cfg_data_i[PostW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weights   <= WeightsReset;
      cfg_q.bias      <= BiasReset;
      cfg_q.prescale  <= PrescaleReset;
      cfg_q.mod_gain  <= ModGainReset;
      cfg_q.use_relu  <= UseReluReset;
      cfg_q.postscale <= PostscaleReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/fina_mac.sv
module fina_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  fina_pkg::in_req_t    req_i,
  input  fina_pkg::cfg_t       cfg_i,
  output fina_pkg::pre_stage_t pre_o
);
  import fina_pkg::*;

  logic signed [SampleW-1:0] samples [NumTaps];
  logic signed [ProdW-1:0]   tap_prod_d [NumTaps];
  logic signed [ProdW-1:0]   tap_prod_q [NumTaps];
  logic signed [ProdW-1:0]   mod_prod_d, mod_prod_q;
  logic signed [AccW-1:0]    acc_d, acc_q;
  logic signed [ScaleW-1:0]  scale_d, scale_q;
  logic signed [PreW-1:0]    pre_d, pre_q;
  logic                      v1_q, v2_q, v3_q;

  assign samples[0] = req_i.in_1;
  assign samples[1] = req_i.in_2;
  assign samples[2] = req_i.in_3;
  assign samples[3] = req_i.in_4;
  assign samples[4] = req_i.in_5;

  // Stage 1: six parallel 12x16 products
  always_comb begin
    for (int k = 0; k < NumTaps; k++) begin
      tap_prod_d[k] = ProdW'(signed'(cfg_i.weights[k*CoefW +: CoefW])) * ProdW'(samples[k]);
    end
    mod_prod_d = ProdW'(cfg_i.mod_gain) * ProdW'(req_i.mod_in);
  end

  // Stage 2: weighted sum plus bias, and the combined scale, both Q.18
  always_comb begin
    acc_d = AccW'(cfg_i.bias) <<< InFracW;
    for (int k = 0; k < NumTaps; k++) begin
      acc_d = acc_d + AccW'(tap_prod_q[k]);
    end
    scale_d = (ScaleW'(cfg_i.prescale) <<< InFracW) + ScaleW'(mod_prod_q);
  end

  // Stage 3: sum times scale, Q.36
  assign pre_d = PreW'(acc_q) * PreW'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_prod_q <= tap_prod_d;
      mod_prod_q <= mod_prod_d;
      acc_q      <= acc_d;
      scale_q    <= scale_d;
      pre_q      <= pre_d;
    end
  end

  assign pre_o = '{valid: v3_q, pre: pre_q};

endmodule

// File: rtl/fina_act.sv
module fina_act #(
  parameter int unsigned TANH_TABLE_ENTRIES = fina_pkg::TanhEntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 use_relu_i,
  input  fina_pkg::pre_stage_t pre_i,
  output fina_pkg::act_stage_t act_o
);
  import fina_pkg::*;

  localparam int unsigned Entries = TANH_TABLE_ENTRIES;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned PosW    = AbsW + $clog2(Entries + 1);
  localparam int unsigned SumW    = PreW + 1;
  localparam int unsigned MulW    = KnotW + AbsW;
  localparam int unsigned RomW    = 2 * KnotW;

  localparam logic [AbsW-1:0]          Lim      = AbsW'(1) << (AbsW - 1);
  localparam logic signed [SumW-1:0]   PreHalf  = SumW'(1) << (PreShift - 1);
  localparam logic signed [ActW-1:0]   ReluMax  = ActW'(1) << (ActW - 2);
  localparam logic [MulW:0]            InterpHalf = (MulW + 1)'(1) << (AbsW - 2);

  // Each entry holds {slope to next knot, knot}
  typedef logic [RomW-1:0] rom_t [Entries];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] prev;
    logic [63:0] cur;
    r    = tanh_ratio(Entries);
    e    = 64'd1 << 30;
    prev = '0;
    for (int i = 1; i <= int'(Entries); i++) begin
      e   = tanh_next_e(e, r);
      cur = tanh_knot(e);
      rom[i-1] = {KnotW'((cur >= prev) ? cur - prev : 64'd0), KnotW'(prev)};
      prev = cur;
    end
    return rom;
  endfunction

  localparam rom_t TanhRom = build_rom();

  logic                    v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [SumW-1:0]  pre_rnd;
  logic signed [PW-1:0]    p_d, p_q;
  logic [PW-1:0]           mag;
  logic                    neg_d, neg2_q, neg3_q, neg4_q;
  logic [AbsW-1:0]         a_d, a_q;
  logic signed [ActW-1:0]  relu_d, relu2_q, relu3_q, relu4_q;
  logic [PosW-1:0]         pos;
  logic [IdxW-1:0]         idx;
  logic [AbsW-1:0]         frac_d, frac_q;
  logic [RomW-1:0]         rom_q;
  logic [MulW-1:0]         mul_d, mul_q;
  logic [KnotW-1:0]        knot_q;
  logic [MulW:0]           interp;
  logic [KnotW-1:0]        y;
  logic signed [ActW-1:0]  act_d, act_q;

  // Stage 1: round Q.36 down to Q.16, half up
  always_comb begin
    pre_rnd = SumW'(pre_i.pre) + PreHalf;
    p_d     = PW'(pre_rnd >>> PreShift);
  end

  // Stage 2: magnitude clamped to 8.0 for tanh, ReLU value clamped far above clip level
  always_comb begin
    neg_d = p_q[PW-1];
    mag   = neg_d ? PW'(-p_q) : PW'(p_q);
    a_d   = (mag > PW'(Lim)) ? Lim : mag[AbsW-1:0];
    if (neg_d || p_q == '0) begin
      relu_d = '0;
    end else if (p_q > PW'(ReluMax)) begin
      relu_d = ReluMax;
    end else begin
      relu_d = ActW'(p_q);
    end
  end

  // Stage 3: table index and fraction, registered table read
  always_comb begin
    pos = PosW'(a_q) * PosW'(Entries);
    if (a_q == Lim) begin
      idx    = IdxW'(Entries - 1);
      frac_d = Lim;
    end else begin
      idx    = pos[AbsW-1 +: IdxW];
      frac_d = {1'b0, pos[AbsW-2:0]};
    end
  end

  // Stage 4: slope times fraction
  assign mul_d = MulW'(rom_q[RomW-1:KnotW]) * MulW'(frac_q);

  // Stage 5: interpolate, restore sign, pick activation
  always_comb begin
    interp = (MulW + 1)'(mul_q) + InterpHalf;
    y      = knot_q + KnotW'(interp >> (AbsW - 1));
    if (use_relu_i) begin
      act_d = relu4_q;
    end else if (neg4_q) begin
      act_d = -signed'(ActW'(y));
    end else begin
      act_d = signed'(ActW'(y));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= pre_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      neg2_q  <= neg_d;
      a_q     <= a_d;
      relu2_q <= relu_d;
      rom_q   <= TanhRom[idx];
      frac_q  <= frac_d;
      neg3_q  <= neg2_q;
      relu3_q <= relu2_q;
      mul_q   <= mul_d;
      knot_q  <= rom_q[KnotW-1:0];
      neg4_q  <= neg3_q;
      relu4_q <= relu3_q;
      act_q   <= act_d;
    end
  end

  assign act_o = '{valid: v5_q, act: act_q};

endmodule

// File: rtl/fina_post.sv
module fina_post (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [fina_pkg::PostW-1:0] postscale_i,
  input  fina_pkg::act_stage_t      act_i,
  output logic                      rsp_valid_o,
  output fina_pkg::out_rsp_t        rsp_o
);
  import fina_pkg::*;

  localparam int unsigned RndW = PostProdW + 1;
  localparam logic signed [RndW-1:0] PostHalf = RndW'(1) << (PostShift - 1);

  logic                        v1_q, v2_q;
  logic signed [PostProdW-1:0] prod_d, prod_q;
  logic signed [RndW-1:0]      rnd;
  logic signed [RndW-1:0]      o_wide;
  out_rsp_t                    rsp_d, rsp_q;

  // Stage 1: activation times unsigned postscale, Q.24
  assign prod_d = PostProdW'(act_i.act) * PostProdW'(signed'({1'b0, postscale_i}));

  // Stage 2: round half up to Q.10 and clip to 16 bits
  always_comb begin
    rnd    = RndW'(prod_q) + PostHalf;
    o_wide = rnd >>> PostShift;
    if (o_wide > RndW'(OutMax)) begin
      rsp_d.out_value = OutMax;
      rsp_d.saturated = 1'b1;
    end else if (o_wide < RndW'(OutMin)) begin
      rsp_d.out_value = OutMin;
      rsp_d.saturated = 1'b1;
    end else begin
      rsp_d.out_value = OutW'(o_wide);
      rsp_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= act_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      rsp_q  <= rsp_d;
    end
  end

  assign rsp_valid_o = v2_q;
  assign rsp_o       = rsp_q;

endmodule

// File: rtl/five_input_neuron_activation.sv
// Five-input neuron: weighted sum of five Q5.10 samples with Q3.8 weights and
// bias, scaled by prescale plus mod_gain times mod_in, then ReLU or tanh
// (256-knot interpolated table by default, argument clamped to +-8), times
// postscale, rounded and saturated to Q5.10 with a flag. One request is taken
// every clock unless the output stalls; it passes three multiply/accumulate
// stages, five activation stages (rounding, clamp, table read, slope multiply,
// interpolation) and two postscale stages. The pipeline moves as one: when a
// result sits unread on the output, every stage holds and in_i.ready is low.
// Registers must be written through the cfg port only while no request is in
// flight, not enforced by the block; the table is a constant ROM, no clearing.
module five_input_neuron_activation #(
  parameter int unsigned TANH_TABLE_ENTRIES = fina_pkg::TanhEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fina_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fina_pkg::CfgDataW-1:0] cfg_data_i,
  fina_stream_if.sink                   in_i,
  fina_stream_if.source                 out_o
);
  import fina_pkg::*;

  cfg_t       cfg;
  logic       en;
  pre_stage_t pre_stage;
  act_stage_t act_stage;
  logic       rsp_valid;
  out_rsp_t   rsp;

  // Whole pipeline advances unless the output holds an unread result
  assign en         = !rsp_valid || out_o.ready;
  assign in_i.ready = en;

  fina_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fina_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_i.valid),
    .req_i      (in_i.payload),
    .cfg_i      (cfg),
    .pre_o      (pre_stage)
  );

  fina_act #(
    .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
  ) u_act (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .use_relu_i (cfg.use_relu),
    .pre_i      (pre_stage),
    .act_o      (act_stage)
  );

  fina_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .postscale_i (cfg.postscale),
    .act_i       (act_stage),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  assign out_o.valid   = rsp_valid;
  assign out_o.payload = rsp;

endmodule

// File: rtl/fina_checker.sv
module fina_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [fina_pkg::OutW-1:0] out_value_i,
  input logic                         saturated_i
);
  import fina_pkg::*;

  // Nothing comes out while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // An empty output never blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // A flagged result sits at one of the clip levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> out_value_i == OutMax || out_value_i == OutMin)
    else $error("saturated flag set on an unclipped value");

  // A result not taken stays unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(saturated_i))
    else $error("stalled result changed");

endmodule

bind five_input_neuron_activation fina_checker u_fina_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.payload.out_value),
  .saturated_i (out_o.payload.saturated)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fina_pkg::*;

  localparam int KnotCount   = TanhEntriesDefault;
  localparam int ResetCycles = 12;
  localparam int DrainCycles = 12;
  localparam int StuckLimit  = 1000;
  localparam int NumPhases   = 12;
  localparam int PhaseReqs   = 90;

  // indexes past the register file; writes there must change nothing
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  // tanh argument limit, 8.0 in Q.16
  localparam longint ClampQ16 = 64'sd1 << 19;

  typedef enum logic {RowReg, RowReq} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    in_req_t             req;
    logic                typed;
    out_rsp_t            want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  fina_stream_if #(.payload_t(in_req_t))  req_if ();
  fina_stream_if #(.payload_t(out_rsp_t)) rsp_if ();

  five_input_neuron_activation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // local copy of the register file
  logic [WeightsW-1:0]     w_packed;
  logic signed [CoefW-1:0] bias_q8;
  logic signed [CoefW-1:0] prescale_q8;
  logic signed [CoefW-1:0] gain_q8;
  logic                    relu_sel;
  logic [PostW-1:0]        post_q8;

  longint    knot_q16 [0:KnotCount];
  out_rsp_t  predicted_outputs [$];
  plan_row_t plan_q [$];
  out_rsp_t  expected_rsp;

  int idle_odds       = 0;
  int mismatches      = 0;
  int reqs_sent       = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int stuck_cycles    = 0;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // tanh knots: exp(-2x) stepped in Q.30, knot = (1-e)/(1+e) in Q.16
  function automatic void build_knots();
    longint unsigned one, step, term, ratio, e, den;
    longint          sum;
    one  = 64'd1 << 30;
    step = (64'd16 << 30) / 64'(KnotCount);
    sum  = longint'(one);
    term = one;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * step) >> 30) / 64'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else            sum += longint'(term);
    end
    ratio = (sum > 0) ? 64'(sum) : 64'd0;
    e = one;
    knot_q16[0] = 0;
    for (int i = 1; i <= KnotCount; i++) begin
      e = (e * ratio + (one >> 1)) >> 30;
      if (e > one) e = one;
      den = one + e;
      knot_q16[i] = longint'((((one - e) << 16) + (den >> 1)) / den);
    end
  endfunction

  function automatic longint tap(input int k);
    return longint'($signed(w_packed[CoefW*k +: CoefW]));
  endfunction

  // full neuron: weighted sum, scale, activation, postscale, saturation
  function automatic out_rsp_t neuron_out(input in_req_t r);
    longint   acc, scale, p, act, o, mag, pos, idx, frac, t0, t1;
    out_rsp_t res;
    acc = longint'(bias_q8) * 1024
        + tap(0) * longint'($signed(r.in_1)) + tap(1) * longint'($signed(r.in_2))
        + tap(2) * longint'($signed(r.in_3)) + tap(3) * longint'($signed(r.in_4))
        + tap(4) * longint'($signed(r.in_5));
    scale = longint'(prescale_q8) * 1024 + longint'(gain_q8) * longint'($signed(r.mod_in));
    // Q.36 -> Q.16, round half up
    p = (acc * scale + (64'sd1 << 19)) >>> 20;
    if (relu_sel) begin
      act = (p > 0) ? p : 0;
    end else begin
      mag = (p < 0) ? -p : p;
      if (mag > ClampQ16) mag = ClampQ16;
      pos  = mag * KnotCount;
      idx  = pos >>> 19;
      frac = pos & (ClampQ16 - 1);
      // at or past 8.0: last knot
      if (idx >= KnotCount) begin
        idx  = KnotCount - 1;
        frac = ClampQ16;
      end
      t0 = knot_q16[idx];
      t1 = knot_q16[idx + 1];
      if (t1 < t0) t1 = t0;
      act = t0 + (((t1 - t0) * frac + (ClampQ16 >>> 1)) >>> 19);
      if (p < 0) act = -act;
    end
    // Q.24 -> Q.10, round half up, then clip
    o = (act * longint'(post_q8) + (64'sd1 << 13)) >>> 14;
    res.saturated = 1'b0;
    if (o > 32767) begin
      o = 32767;
      res.saturated = 1'b1;
    end else if (o < -32768) begin
      o = -32768;
      res.saturated = 1'b1;
    end
    res.out_value = o[OutW-1:0];
    return res;
  endfunction

  function automatic void plan_reg(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = RowReg;
    row.idx  = idx;
    row.data = data;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_req(input int a, b, c, d, e, m, input bit typed = 1'b0,
                                   input int want = 0, input bit want_sat = 1'b0);
    plan_row_t row;
    row                     = '0;
    row.kind                = RowReq;
    row.req.in_1            = SampleW'(a);
    row.req.in_2            = SampleW'(b);
    row.req.in_3            = SampleW'(c);
    row.req.in_4            = SampleW'(d);
    row.req.in_5            = SampleW'(e);
    row.req.mod_in          = SampleW'(m);
    row.typed               = typed;
    row.want.out_value      = OutW'(want);
    row.want.saturated      = want_sat;
    plan_q.push_back(row);
  endfunction

  // narrow register value with random junk above it
  function automatic logic [CfgDataW-1:0] pad(input logic [CoefW-1:0] v);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'({$urandom, $urandom});
    d[CoefW-1:0] = v;
    return d;
  endfunction

  function automatic logic [CoefW-1:0] rand_coef();
    int v;
    case ($urandom_range(5, 0))
      0:       v = $urandom;
      1:       v = ($urandom_range(1, 0) != 0) ? 1280 : -1280;
      default: v = (int'($urandom_range(2560, 0)) - 1280) >>> $urandom_range(8, 0);
    endcase
    return CoefW'(v);
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    logic signed [SampleW-1:0] v;
    v = SampleW'($urandom);
    case ($urandom_range(7, 0))
      0:       v = ($urandom_range(1, 0) != 0) ? 16'sh7fff : 16'sh8000;
      1:       v = '0;
      2, 3, 4: v = v >>> $urandom_range(14, 3);
      default: ;
    endcase
    return v;
  endfunction

  // register write, only once every request in flight has come back
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    req_if.valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      RegWeights:   w_packed    = data[WeightsW-1:0];
      RegBias:      bias_q8     = data[CoefW-1:0];
      RegPrescale:  prescale_q8 = data[CoefW-1:0];
      RegModGain:   gain_q8     = data[CoefW-1:0];
      RegUseRelu:   relu_sel    = data[0];
      RegPostscale: post_q8     = data[PostW-1:0];
      default:      ;
    endcase
    reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one request; valid stays high afterwards unless a gap is drawn
  task automatic push_request(input in_req_t r, input bit typed, input out_rsp_t typed_rsp);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted_outputs.push_back(typed ? typed_rsp : neuron_out(r));
    reqs_sent++;
    if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
  endtask

  // result side: random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(14, 0);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (predicted_outputs.size() == 0) begin
        $error("result with no request pending: out_value %0d",
               rsp_if.payload.out_value);
        mismatches++;
      end else begin
        expected_rsp = predicted_outputs.pop_front();
        if (rsp_if.payload.out_value !== expected_rsp.out_value) begin
          $error("out_value: expected %0d, actual %0d",
                 expected_rsp.out_value, rsp_if.payload.out_value);
          mismatches++;
        end
        if (rsp_if.payload.saturated !== expected_rsp.saturated) begin
          $error("saturated: expected %0b, actual %0b",
                 expected_rsp.saturated, rsp_if.payload.saturated);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we_i)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [WeightsW-1:0] wts;
    in_req_t             req;
    plan_row_t           row;
    int                  directed_reqs;

    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;

    w_packed    = '0;
    bias_q8     = 12'sd0;
    prescale_q8 = 12'sd256;
    gain_q8     = 12'sd0;
    relu_sel    = 1'b0;
    post_q8     = 12'd1280;
    build_knots();

    // after reset all weights are zero, so everything comes out zero
    plan_req(0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0);
    plan_req(32767, 32767, 32767, 32767, 32767, 32767, 1'b1, 0, 1'b0);
    plan_req(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 0, 1'b0);
    // unit weights and scales with ReLU: output is the plain sum
    plan_reg(RegWeights, {NumTaps{12'h100}});
    plan_reg(RegPostscale, CfgDataW'(256));
    plan_reg(RegUseRelu, CfgDataW'(1));
    plan_req(1024, 0, 0, 0, 0, 0, 1'b1, 1024, 1'b0);
    plan_req(1024, 1024, 1024, 1024, 1024, 0, 1'b1, 5120, 1'b0);
    plan_req(1, 0, 0, 0, 0, -32768, 1'b1, 1, 1'b0);
    plan_req(-1, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0);
    plan_req(32767, 32767, 32767, 32767, 32767, 0, 1'b1, 32767, 1'b1);
    plan_req(-32768, -32768, -32768, -32768, -32768, 0, 1'b1, 0, 1'b0);
    // tanh around the clamp at 8.0
    plan_reg(RegUseRelu, CfgDataW'(0));
    plan_req(0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0);
    plan_req(8192, 0, 0, 0, 0, 0);
    plan_req(-8192, 0, 0, 0, 0, 0);
    plan_req(8191, 0, 0, 0, 0, 0);
    plan_req(512, 0, 0, 0, 0, 0);
    plan_req(32767, 32767, 32767, 32767, 32767, 0);
    // postscale past its nominal range, then zero
    plan_reg(RegPostscale, CfgDataW'(4095));
    plan_req(8192, 0, 0, 0, 0, 0);
    plan_req(-32768, 0, 0, 0, 0, 0);
    plan_reg(RegPostscale, CfgDataW'(0));
    plan_req(32767, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0);
    // bias, prescale and modulation gain at their range ends
    plan_reg(RegBias, CfgDataW'(1280));
    plan_reg(RegPrescale, CfgDataW'(-1280));
    plan_reg(RegModGain, CfgDataW'(1280));
    plan_reg(RegPostscale, CfgDataW'(2560));
    plan_reg(RegUseRelu, CfgDataW'(1));
    plan_req(0, 0, 0, 0, 0, 0);
    plan_req(0, 0, 0, 0, 0, 32767);
    plan_req(0, 0, 0, 0, 0, -32768);
    // spare indexes must be dropped; distinct weights per tap
    plan_reg(RegSpareA, '1);
    plan_reg(RegSpareB, {NumTaps{12'ha5a}});
    plan_reg(RegWeights, {12'h100, 12'hfff, 12'h001, 12'h800, 12'h7ff});
    plan_req(1024, -1024, 2048, 300, -700, 0);
    plan_reg(RegBias, CfgDataW'(-1280));
    plan_reg(RegModGain, CfgDataW'(-1280));
    plan_reg(RegUseRelu, CfgDataW'(0));
    plan_req(300, -200, 100, 50, -25, 32767);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    idle_odds = 4;
    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == RowReg) write_reg(row.idx, row.data);
      else                    push_request(row.req, row.typed, row.want);
    end
    directed_reqs = reqs_sent;

    // random phases, each under its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          // every register at its top end
          write_reg(RegWeights, {NumTaps{12'h7ff}});
          write_reg(RegBias, pad(12'h7ff));
          write_reg(RegPrescale, pad(12'h7ff));
          write_reg(RegModGain, pad(12'h7ff));
          write_reg(RegUseRelu, pad(12'h001));
          write_reg(RegPostscale, pad(12'hfff));
        end
        1: begin
          // signed registers at the bottom end
          write_reg(RegWeights, {NumTaps{12'h800}});
          write_reg(RegBias, pad(12'h800));
          write_reg(RegPrescale, pad(12'h800));
          write_reg(RegModGain, pad(12'h800));
          write_reg(RegUseRelu, pad(12'h000));
          write_reg(RegPostscale, pad(12'd2560));
        end
        default: begin
          for (int k = 0; k < NumTaps; k++) wts[CoefW*k +: CoefW] = rand_coef();
          write_reg(RegWeights, wts);
          write_reg(RegBias, pad(rand_coef()));
          write_reg(RegPrescale, pad(rand_coef()));
          write_reg(RegModGain, ($urandom_range(2, 0) == 0) ? pad(12'd0) : pad(rand_coef()));
          write_reg(RegUseRelu, pad(CoefW'($urandom_range(1, 0))));
          case ($urandom_range(3, 0))
            0:       write_reg(RegPostscale, pad(12'd0));
            1:       write_reg(RegPostscale, pad(12'd2560));
            2:       write_reg(RegPostscale, pad(12'hfff));
            default: write_reg(RegPostscale, pad(CoefW'($urandom_range(2560, 0))));
          endcase
          if ($urandom_range(2, 0) == 0)
            write_reg(($urandom_range(1, 0) != 0) ? RegSpareA : RegSpareB,
                      CfgDataW'({$urandom, $urandom}));
        end
      endcase

      // no idling in the last phase; otherwise none, light or heavy
      if (ph == NumPhases - 1) begin
        idle_odds = 0;
      end else begin
        case (ph % 3)
          0:       idle_odds = 0;
          1:       idle_odds = 10;
          default: idle_odds = 3;
        endcase
      end

      for (int n = 0; n < PhaseReqs; n++) begin
        req.in_1   = rand_sample();
        req.in_2   = rand_sample();
        req.in_3   = rand_sample();
        req.in_4   = rand_sample();
        req.in_5   = rand_sample();
        req.mod_in = rand_sample();
        push_request(req, 1'b0, '0);
      end
    end

    // drain
    req_if.valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests (%0d from the directed table) over %0d register writes",
             reqs_sent, directed_reqs, reg_writes);
    $display("compared %0d results in ReLU and tanh modes, %0d random settings",
             results_checked, NumPhases);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fina_pkg.sv
rtl/fina_stream_if.sv
rtl/fina_cfg_regs.sv
rtl/fina_mac.sv
rtl/fina_act.sv
rtl/fina_post.sv
rtl/five_input_neuron_activation.sv
rtl/fina_checker.sv
bench/tb_top.sv
